### rtl/ilid_pkg.sv
package ilid_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   // Positions and counts are compared at a width that holds both.
   localparam int CMP_W    = (COUNT_W > 7) ? COUNT_W : 7;

   localparam int DATA_W     = 32;
   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 8;
   localparam int STATUS_W   = 2;
   localparam int LENGTH_W   = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ = 3'd0,
      ACT_HEAD = 3'd1,
      ACT_TAIL = 3'd2,
      ACT_AT   = 3'd3,
      ACT_DEL  = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cmd_type;

endpackage

### rtl/ilid_cell.sv
module ilid_cell
   import ilid_pkg::*;
(
   input  logic              clock,
   input  cmd_type           cmd,
   input  logic [IDX_W-1:0]  cell_idx,
   input  logic [DATA_W-1:0] left_entry,
   input  logic [DATA_W-1:0] right_entry,
   output logic [DATA_W-1:0] entry,
   output logic [DATA_W-1:0] read_data
);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic [CMP_W-1:0]  idx_ext;

   assign idx_ext = CMP_W'(cell_idx);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (idx_ext > cmd.pos) begin
            entry_in = left_entry;
         end else if (idx_ext == cmd.pos) begin
            entry_in = cmd.value;
         end
      end else if (cmd.del) begin
         if (idx_ext >= cmd.pos) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign read_data = (idx_ext == cmd.pos) ? entry_ff : '0;

endmodule

### rtl/indexed_list_insert_delete.sv
// Ordered store of up to CAPACITY signed 32-bit values held in a row of cells, one value
// per cell. Each request beat on req_ reads, inserts (at head, tail or before a position)
// or deletes one value and yields exactly one response beat on rsp_ with the read data,
// a hit flag, a status code and the length after the request. Every cell updates in the
// cycle the request is accepted, so an insert or delete shifts all later values at once,
// and a read selects its cell through an AND-OR over the row. A new request is accepted
// each cycle as long as the response register is empty or its beat is taken in that same
// cycle. Values never written read as unknown, but only positions below the length are
// ever returned.
module indexed_list_insert_delete
   import ilid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position[7:0], value[39:8]
   input  logic [ACTION_W-1:0]   req_tuser,  // action[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // read_value[31:0], status[33:32],
                                             // length[40:34], zero[47:41]
   output logic                  rsp_tuser   // hit[0]
);

   logic                  fire;
   logic [POSITION_W-1:0] req_position;
   logic [DATA_W-1:0]     req_value;
   action_type            req_action;
   logic                  pos_neg;
   logic [CMP_W-1:0]      pos_u;
   logic [CMP_W-1:0]      count_c;
   logic                  full;
   logic                  in_range;

   cmd_type               cmd;
   logic                  do_ins;
   logic                  do_del;
   logic                  hit_c;
   status_type            status_c;

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_W-1:0]     rsp_value_ff;
   logic [DATA_W-1:0]     rsp_value_in;
   logic                  rsp_hit_ff;
   logic                  rsp_hit_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic [LENGTH_W-1:0]   rsp_length_ff;
   logic [LENGTH_W-1:0]   rsp_length_in;

   logic [DATA_W-1:0]     entry_w [CAPACITY];
   logic [DATA_W-1:0]     read_w  [CAPACITY];
   logic [DATA_W-1:0]     read_or;

   assign req_position = req_tdata[POSITION_W-1:0];
   assign req_value    = req_tdata[POSITION_W +: DATA_W];
   assign req_action   = action_type'(req_tuser);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   assign pos_neg  = req_position[POSITION_W-1];
   assign pos_u    = CMP_W'(req_position[POSITION_W-2:0]);
   assign count_c  = CMP_W'(count_ff);
   assign full     = (count_c >= CMP_W'(CAPACITY));
   assign in_range = !pos_neg && (pos_u < count_c);

   // Request decode: where the row acts and what the response reports.
   always_comb begin
      do_ins    = 1'b0;
      do_del    = 1'b0;
      hit_c     = 1'b0;
      status_c  = ST_DONE;
      cmd.pos   = pos_u;
      cmd.value = req_value;
      case (req_action)
         ACT_READ: begin
            if (in_range) begin
               hit_c = 1'b1;
            end else begin
               status_c = ST_RANGE;
            end
         end
         ACT_HEAD: begin
            cmd.pos = '0;
            if (full) begin
               status_c = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ACT_TAIL: begin
            cmd.pos = count_c;
            if (full) begin
               status_c = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ACT_AT: begin
            if (pos_neg) begin
               cmd.pos = '0;
            end
            if (!pos_neg && (pos_u > count_c)) begin
               status_c = ST_RANGE;
            end else if (full) begin
               status_c = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ACT_DEL: begin
            if (in_range) begin
               do_del = 1'b1;
            end else begin
               status_c = ST_RANGE;
            end
         end
         default: begin
            status_c = ST_RANGE;
         end
      endcase
      cmd.ins = fire && do_ins;
      cmd.del = fire && do_del;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = entry_w[i];
      end else begin : g_mid_left
         assign left_w = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = entry_w[i];
      end else begin : g_mid_right
         assign right_w = entry_w[i+1];
      end

      ilid_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (IDX_W'(i)),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_w[i]),
         .read_data   (read_w[i])
      );
   end

   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | read_w[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.del) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = hit_c ? read_or : '0;
         rsp_hit_in    = hit_c;
         rsp_status_in = status_c;
         rsp_length_in = LENGTH_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DATA_W - STATUS_W - LENGTH_W){1'b0}},
                        rsp_length_ff, rsp_status_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_hit_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_c <= CMP_W'(CAPACITY))
      else $error("stored length exceeds capacity");

   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted request left no response");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      fire && full && (req_action == ACT_HEAD || req_action == ACT_TAIL)
      |=> rsp_status_ff == ST_FULL && $stable(count_ff))
      else $error("insert into a full store was not refused");

   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_status_ff == ST_DONE)
      else $error("read hit with a non-done status");

   a_del_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.del |=> COUNT_W'(count_ff + COUNT_W'(1)) == $past(count_ff))
      else $error("delete did not shorten the store by one");
`endif

endmodule

### verif/indexed_list_insert_delete_tb.sv
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;
   import ilid_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD  = 300;
   localparam int HOLD_AT    = 250;

   // Action codes the block does not define; each must come back with a range status.
   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_MID_UNUSED   = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;

   typedef struct {
      logic                         drain;
      logic [ACTION_W-1:0]          act;
      logic signed [POSITION_W-1:0] pos;
      logic [DATA_W-1:0]            value;
   } list_req_type;

   typedef struct {
      logic [DATA_W-1:0]   read_value;
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [LENGTH_W-1:0] length;
   } list_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // position[7:0], value[39:8]
   logic [ACTION_W-1:0]   req_tuser = '0;  // action[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // read_value[31:0], status[33:32],
                                           // length[40:34], zero[47:41]
   logic                  rsp_tuser;       // hit[0]

   list_req_type      pending_req_q[$];
   list_rsp_type      expected_rsp_q[$];
   logic [DATA_W-1:0] list_model_q[$];

   int           mismatches = 0;
   int           est_len = 0;
   int           send_wait = 0;
   logic         send_calm = 1'b0;
   list_req_type cur_req;
   int           hold_cnt = 0;
   logic         recv_calm = 1'b0;
   int           rsp_seen = 0;
   int           idle_cycles = 0;

   indexed_list_insert_delete DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [STATUS_W-1:0] list_insert(int slot, logic [DATA_W-1:0] v);
      if (list_model_q.size() >= CAPACITY)
         return ST_FULL;
      list_model_q.insert(slot, v);
      return ST_DONE;
   endfunction

   // Applies one request to the model list and returns the response it should produce.
   function automatic list_rsp_type list_apply(list_req_type r);
      list_rsp_type e;
      int           n;
      int           p;
      e.read_value = '0;
      e.hit        = 1'b0;
      e.status     = ST_DONE;
      n = list_model_q.size();
      p = r.pos;
      case (r.act)
         ACT_READ: begin
            if (p >= 0 && p < n) begin
               e.read_value = list_model_q[p];
               e.hit        = 1'b1;
            end else begin
               e.status = ST_RANGE;
            end
         end
         ACT_HEAD: e.status = list_insert(0, r.value);
         ACT_TAIL: e.status = list_insert(n, r.value);
         ACT_AT: begin
            // The range check wins over the full check.
            if (p > n)
               e.status = ST_RANGE;
            else
               e.status = list_insert((p < 0) ? 0 : p, r.value);
         end
         ACT_DEL: begin
            if (p >= 0 && p < n)
               list_model_q.delete(p);
            else
               e.status = ST_RANGE;
         end
         default: e.status = ST_RANGE;
      endcase
      e.length = LENGTH_W'(list_model_q.size());
      return e;
   endfunction

   // Queues one request and keeps a rough length so positions can be aimed near the end.
   task automatic queue_req(logic [ACTION_W-1:0] act, int pos, logic [DATA_W-1:0] value);
      list_req_type r;
      logic signed [POSITION_W-1:0] p8;
      p8 = POSITION_W'(pos);
      r.drain = 1'b0;
      r.act   = act;
      r.pos   = p8;
      r.value = value;
      pending_req_q.push_back(r);
      case (act)
         ACT_HEAD, ACT_TAIL: if (est_len < CAPACITY) est_len++;
         ACT_AT: if (!(p8 >= 0 && int'(p8) > est_len) && est_len < CAPACITY) est_len++;
         ACT_DEL: if (p8 >= 0 && int'(p8) < est_len) est_len--;
         default: ;
      endcase
   endtask

   task automatic queue_drain();
      list_req_type r;
      r.drain = 1'b1;
      r.act   = ACT_READ;
      r.pos   = '0;
      r.value = '0;
      pending_req_q.push_back(r);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 31))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_pos(int top);
      if ($urandom_range(0, 99) < 15)
         return $urandom_range(0, 255);
      return $urandom_range(0, top);
   endfunction

   task automatic queue_random(int grow_pct, int del_pct);
      int r;
      int pick;
      logic [ACTION_W-1:0] act;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         act = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
      else if (pick < 5 + del_pct)
         act = ACT_DEL;
      else if (pick < 5 + del_pct + grow_pct) begin
         r = $urandom_range(0, 2);
         act = (r == 0) ? ACT_HEAD : (r == 1) ? ACT_TAIL : ACT_AT;
      end else
         act = ACT_READ;
      queue_req(act, pick_pos((act == ACT_AT) ? est_len + 1 : est_len), pick_value());
   endtask

   // Driver: one request beat at a time, with a random gap before each.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_rsp_q.push_back(list_apply(cur_req));
            if ($urandom_range(0, 39) == 0)
               send_calm = ~send_calm;
            send_wait = send_calm ? 0 : $urandom_range(0, 11);
         end
         if (send_wait > 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_req_q.size() != 0 && pending_req_q[0].drain) begin
            // Hold the input until every outstanding response has come back.
            req_tvalid <= 1'b0;
            if (expected_rsp_q.size() == 0)
               void'(pending_req_q.pop_front());
         end else if (pending_req_q.size() != 0) begin
            cur_req = pending_req_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {cur_req.value, cur_req.pos};
            req_tuser  <= cur_req.act;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response beat and draws the stall before the next one.
   always @(posedge clock) begin : monitor
      list_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               $error("response beat with no request outstanding");
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_tdata[31:0] !== e.read_value) begin
                  mismatches++;
                  $error("read_value: expected %h, got %h", e.read_value, rsp_tdata[31:0]);
               end
               if (rsp_tuser !== e.hit) begin
                  mismatches++;
                  $error("hit: expected %b, got %b", e.hit, rsp_tuser);
               end
               if (rsp_tdata[33:32] !== e.status) begin
                  mismatches++;
                  $error("status: expected %0d, got %0d", e.status, rsp_tdata[33:32]);
               end
               if (rsp_tdata[40:34] !== e.length) begin
                  mismatches++;
                  $error("length: expected %0d, got %0d", e.length, rsp_tdata[40:34]);
               end
            end
            if ($urandom_range(0, 39) == 0)
               recv_calm = ~recv_calm;
            // One long hold lets requests pile up against a full output.
            if (rsp_seen == HOLD_AT)
               hold_cnt = LONG_HOLD;
            else
               hold_cnt = recv_calm ? 0 : $urandom_range(0, 11);
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Empty store first: reads and a delete miss and a position past the end is ignored.
      queue_req(ACT_READ, 0, 32'h0);
      queue_req(ACT_READ, -128, 32'h0);
      queue_req(ACT_DEL, 0, 32'hffff_ffff);
      queue_req(ACT_AT, 1, 32'h1234_5678);
      queue_req(ACT_AT, -128, 32'h8000_0000);
      queue_req(ACT_TAIL, 127, 32'h7fff_ffff);
      queue_req(ACT_HEAD, -1, 32'h0000_0000);
      queue_req(ACT_AT, 1, 32'hffff_ffff);
      queue_req(ACT_AT, 4, 32'h5555_aaaa);
      queue_req(ACT_AT, -1, 32'haaaa_5555);
      queue_req(ACT_READ, 0, 32'h0);
      queue_req(ACT_READ, 4, 32'h0);
      queue_req(ACT_READ, 5, 32'h0);
      queue_req(ACT_READ, -1, 32'h0);
      queue_req(ACT_READ, 127, 32'h0);
      queue_req(ACT_DEL, 0, 32'h0);
      queue_req(ACT_DEL, 3, 32'h0);
      queue_req(ACT_DEL, 127, 32'h0);
      queue_req(ACT_DEL, -128, 32'h0);
      queue_req(ACT_FIRST_UNUSED, 0, 32'hffff_ffff);
      queue_req(ACT_MID_UNUSED, -1, 32'h0);
      queue_req(ACT_LAST_UNUSED, 85, 32'h1);
      queue_drain();

      // Alternate growing, shrinking and mixed stretches so the store fills and empties.
      for (int ph = 0; ph < 9; ph++) begin
         for (int i = 0; i < 95; i++) begin
            case (ph % 3)
               0: queue_random(80, 10);
               1: queue_random(10, 70);
               default: queue_random(35, 25);
            endcase
         end
         // At capacity: a position past the end is ignored, any other insert is refused.
         if (ph == 3) begin
            while (est_len < CAPACITY)
               queue_req(ACT_TAIL, 0, pick_value());
            queue_req(ACT_AT, 100, 32'h1);
            queue_req(ACT_AT, CAPACITY, 32'h2);
            queue_req(ACT_AT, -5, 32'h3);
            queue_req(ACT_HEAD, 0, 32'h4);
            queue_req(ACT_READ, CAPACITY - 1, 32'h0);
            queue_drain();
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (pending_req_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0);
      repeat (5) @(posedge clock);

      if (mismatches == 0 && expected_rsp_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
